FILE: design/ogru_pkg.sv
// Package for the occupancy grid ray update unit: sizes, codes, state type,
// the sine table and the fixed-point direction helper.
// Used by the top level, the checker and the bench; depends on nothing.
`timescale 1ns / 1ps
package ogru_pkg;

  localparam int TILE_CELLS = 64;
  localparam int TILE_SLOTS = 4;
  localparam int FRAC_BITS  = 10;

  localparam int CELLS_PER_TILE = TILE_CELLS * TILE_CELLS;
  localparam int MAP_DEPTH      = TILE_SLOTS * CELLS_PER_TILE;
  localparam int ADDR_W         = $clog2(MAP_DEPTH);
  localparam int SLOT_W         = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;
  localparam int CIDX_W         = $clog2(TILE_CELLS);
  localparam int EDGE_W         = $clog2(TILE_CELLS) + FRAC_BITS + 1;
  localparam int POS_W          = ((EDGE_W > 17) ? EDGE_W : 17) + 1;
  localparam int STEP_W         = FRAC_BITS + 2;
  localparam int N_W            = $clog2(TILE_CELLS / 2 + 1);
  localparam int LIM_W          = 16 + $clog2(TILE_CELLS + 1);
  localparam int EDGE_POS       = TILE_CELLS << FRAC_BITS;
  localparam int LAST_POS       = (TILE_CELLS - 1) << FRAC_BITS;

  localparam logic [7:0] CELL_RESET = 8'd127;
  localparam logic [7:0] CELL_MAX   = 8'd255;

  localparam logic [31:0] SLOT0_RESET   = 32'h0000_0000;
  localparam logic [31:0] SLOT1_RESET   = 32'h0000_FFFF;
  localparam logic [31:0] SLOT2_RESET   = 32'hFFFF_0000;
  localparam logic [31:0] SLOT3_RESET   = 32'hFFFF_FFFF;
  localparam logic [3:0]  PRESENT_RESET = 4'hF;
  localparam logic [15:0] PITCH_RESET   = 16'd10;

  localparam logic [2:0] REG_SLOT0   = 3'd0;
  localparam logic [2:0] REG_SLOT1   = 3'd1;
  localparam logic [2:0] REG_SLOT2   = 3'd2;
  localparam logic [2:0] REG_SLOT3   = 3'd3;
  localparam logic [2:0] REG_PRESENT = 3'd4;
  localparam logic [2:0] REG_PITCH   = 3'd5;

  typedef enum logic [2:0] {
    STATUS_DONE    = 3'd0,
    STATUS_NO_TILE = 3'd1,
    STATUS_RANGE   = 3'd2,
    STATUS_MISSING = 3'd3,
    STATUS_READ    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_DIV,
    ST_CELL,
    ST_UPDATE,
    ST_LOOKUP,
    ST_RDREQ,
    ST_RDDATA,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        hit;
    logic [SLOT_W-1:0] idx;
  } slot_hit_t;

  function automatic logic [16:0] quarter_sine(input logic [5:0] k);
    logic [16:0] v;
    case (k)
      6'd0: v = 17'd0;       6'd1: v = 17'd3216;   6'd2: v = 17'd6424;
      6'd3: v = 17'd9616;    6'd4: v = 17'd12785;  6'd5: v = 17'd15924;
      6'd6: v = 17'd19024;   6'd7: v = 17'd22078;  6'd8: v = 17'd25080;
      6'd9: v = 17'd28020;   6'd10: v = 17'd30893; 6'd11: v = 17'd33692;
      6'd12: v = 17'd36410;  6'd13: v = 17'd39040; 6'd14: v = 17'd41576;
      6'd15: v = 17'd44011;  6'd16: v = 17'd46341; 6'd17: v = 17'd48559;
      6'd18: v = 17'd50660;  6'd19: v = 17'd52639; 6'd20: v = 17'd54491;
      6'd21: v = 17'd56212;  6'd22: v = 17'd57798; 6'd23: v = 17'd59244;
      6'd24: v = 17'd60547;  6'd25: v = 17'd61705; 6'd26: v = 17'd62714;
      6'd27: v = 17'd63572;  6'd28: v = 17'd64277; 6'd29: v = 17'd64827;
      6'd30: v = 17'd65220;  6'd31: v = 17'd65457; 6'd32: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Sine of a 128-step angle, rounded half up to FRAC_BITS fraction bits.
  function automatic logic signed [STEP_W-1:0] sine_q(input logic [6:0] idx);
    logic [5:0]  k;
    logic [16:0] v;
    logic [18:0] s;
    logic [STEP_W-1:0] mag;
    k = {1'b0, idx[4:0]};
    v = idx[5] ? quarter_sine(6'd32 - k) : quarter_sine(k);
    s = ({1'b0, v, 1'b0} + (19'd1 << (16 - FRAC_BITS))) >> (17 - FRAC_BITS);
    mag = s[STEP_W-1:0];
    return idx[6] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

FILE: design/ogru_in_if.sv
// Input channel of the ray update unit: valid/ready plus one item.
// Depends on nothing.
`timescale 1ns / 1ps
interface ogru_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [15:0] robot_tile_x;
  logic signed [15:0] robot_tile_y;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [15:0] heading;
  logic [15:0] beam_angle;
  logic [15:0] distance;
  logic [1:0]  read_slot;
  logic [11:0] read_cell;

  modport source (output valid, kind, robot_tile_x, robot_tile_y, start_x, start_y,
                  heading, beam_angle, distance, read_slot, read_cell, input ready);
  modport sink (input valid, kind, robot_tile_x, robot_tile_y, start_x, start_y,
                heading, beam_angle, distance, read_slot, read_cell, output ready);
endinterface

FILE: design/ogru_out_if.sv
// Output channel of the ray update unit: valid/ready plus one result.
// Depends on nothing.
`timescale 1ns / 1ps
interface ogru_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] steps_done;
  logic [7:0] cell_value;

  modport source (output valid, status, steps_done, cell_value, input ready);
  modport sink (input valid, status, steps_done, cell_value, output ready);
endinterface

FILE: design/ogru_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module ogru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/ogru_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module ogru_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] quotient
);
  logic [15:0] rem;
  logic [15:0] dvsr;
  logic [4:0]  cnt;
  logic [16:0] trial;

  assign trial = {rem, quotient[15]} - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 5'd16;
      rem      <= 16'd0;
      quotient <= dividend;
      dvsr     <= divisor;
    end else if (busy) begin
      if (!trial[16]) begin
        rem      <= trial[15:0];
        quotient <= {quotient[14:0], 1'b1};
      end else begin
        rem      <= {rem[14:0], quotient[15]};
        quotient <= {quotient[14:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

FILE: design/occupancy_grid_ray_update_unit.sv
// Top level of the occupancy grid ray update: sequencer, registers, ray march.
// Depends on ogru_pkg, ogru_in_if, ogru_out_if, ogru_ram and ogru_div.
//
//   channel  | direction | transfer when
//   in_ch    | sink      | in_ch.valid && in_ch.ready
//   out_ch   | source    | out_ch.valid && out_ch.ready
//   apb      | slave     | psel && penable && pwrite (pready tied high)
//
// A read item passes the transfer, the map read and its data, and the finish;
// a skipped beam the transfer, the tile lookup and the finish. A marching beam
// passes the transfer, the tile lookup and the range division, then one map
// read and one write per cell, a tile lookup per tile crossing with cells
// left, and the finish. The single map port sets this pace.
// After reset a clearing pass writes 127 into all 16384 cells, one a cycle,
// and no item is taken meanwhile. A stalled result holds the sequencer.
`timescale 1ns / 1ps
module occupancy_grid_ray_update_unit (
  input  logic        clk,
  input  logic        rst,
  ogru_in_if.sink     in_ch,
  ogru_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic signed [ogru_pkg::POS_W-1:0] EDGE_P =
    ogru_pkg::POS_W'(ogru_pkg::EDGE_POS);
  localparam logic signed [ogru_pkg::POS_W-1:0] LAST_P =
    ogru_pkg::POS_W'(ogru_pkg::LAST_POS);

  ogru_pkg::state_t state, state_next;

  logic [31:0] coords [4];
  logic [3:0]  present;
  logic [15:0] pitch;

  logic [ogru_pkg::ADDR_W-1:0] clr_addr;
  logic [ogru_pkg::ADDR_W-1:0] addr_q;
  logic [ogru_pkg::ADDR_W-1:0] cell_addr;
  logic [ogru_pkg::ADDR_W-1:0] rd_addr;

  logic        kind_q;
  logic [15:0] tx, ty, dist_q;
  logic signed [ogru_pkg::POS_W-1:0]  px, py;
  logic signed [ogru_pkg::STEP_W-1:0] dx, dy;
  logic [1:0]  rd_slot;
  logic [11:0] rd_cell;
  logic [ogru_pkg::SLOT_W-1:0] act;
  logic [ogru_pkg::N_W-1:0] n_cells, steps;
  ogru_pkg::status_t status;
  logic [7:0]  cval;

  logic        out_valid;
  logic [2:0]  out_status;
  logic [5:0]  out_steps;
  logic [7:0]  out_value;

  logic        ram_we;
  logic [ogru_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic        div_start, div_busy;
  logic [15:0] quotient;

  ogru_pkg::slot_hit_t look;
  logic [15:0] pitch_eff;
  logic [ogru_pkg::LIM_W-1:0] range_lim;
  logic        too_long, outside, last_cell, crossed, rd_ok, in_xfer, cfg_wr, out_free;
  logic signed [ogru_pkg::POS_W-1:0] npx, npy, wpx, wpy;
  logic [15:0] wtx, wty, ang_sum;
  logic [6:0]  ang_idx;
  logic [7:0]  upd_val;

  function automatic ogru_pkg::slot_hit_t find_slot(input logic [15:0] fx,
                                                    input logic [15:0] fy,
                                                    input logic [31:0] c [4],
                                                    input logic [3:0] p);
    ogru_pkg::slot_hit_t r;
    r = '0;
    for (int i = ogru_pkg::TILE_SLOTS - 1; i >= 0; i--) begin
      if (p[i] && c[i] == {fx, fy}) begin
        r.hit = 1'b1;
        r.idx = ogru_pkg::SLOT_W'(i);
      end
    end
    return r;
  endfunction

  ogru_ram #(.WIDTH(8), .DEPTH(ogru_pkg::MAP_DEPTH)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  ogru_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dist_q),
    .divisor(pitch_eff), .busy(div_busy), .quotient(quotient)
  );

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_status;
  assign out_ch.steps_done = out_steps;
  assign out_ch.cell_value = out_value;

  always_comb begin
    unique case (paddr[4:2])
      ogru_pkg::REG_SLOT0:   prdata = coords[0];
      ogru_pkg::REG_SLOT1:   prdata = coords[1];
      ogru_pkg::REG_SLOT2:   prdata = coords[2];
      ogru_pkg::REG_SLOT3:   prdata = coords[3];
      ogru_pkg::REG_PRESENT: prdata = {28'd0, present};
      ogru_pkg::REG_PITCH:   prdata = {16'd0, pitch};
      default:               prdata = 32'd0;
    endcase
  end

  // Datapath helpers.
  always_comb begin
    pitch_eff = (pitch == 16'd0) ? 16'd1 : pitch;
    range_lim = (ogru_pkg::LIM_W'(pitch_eff) * ogru_pkg::LIM_W'(ogru_pkg::TILE_CELLS)) >> 1;
    too_long  = ogru_pkg::LIM_W'(dist_q) > range_lim;
    look      = find_slot(tx, ty, coords, present);
    ang_sum   = in_ch.heading + in_ch.beam_angle + 16'd256;
    ang_idx   = ang_sum[15:9];
    outside   = px[ogru_pkg::POS_W-1] || py[ogru_pkg::POS_W-1] || (px >= EDGE_P) ||
                (py >= EDGE_P);
    cell_addr = ogru_pkg::ADDR_W'(act) * ogru_pkg::ADDR_W'(ogru_pkg::CELLS_PER_TILE) +
                ogru_pkg::ADDR_W'(py[ogru_pkg::FRAC_BITS +: ogru_pkg::CIDX_W]) *
                ogru_pkg::ADDR_W'(ogru_pkg::TILE_CELLS) +
                ogru_pkg::ADDR_W'(px[ogru_pkg::FRAC_BITS +: ogru_pkg::CIDX_W]);
    rd_ok     = (32'(rd_slot) < 32'(ogru_pkg::TILE_SLOTS)) &&
                (32'(rd_cell) < 32'(ogru_pkg::CELLS_PER_TILE));
    rd_addr   = ogru_pkg::ADDR_W'(rd_slot) * ogru_pkg::ADDR_W'(ogru_pkg::CELLS_PER_TILE) +
                ogru_pkg::ADDR_W'(rd_cell);
    last_cell = ({1'b0, steps} + 1'b1) == {1'b0, n_cells};
    if (last_cell) begin
      upd_val = (ram_rdata == ogru_pkg::CELL_MAX) ? ram_rdata : ram_rdata + 8'd1;
    end else begin
      upd_val = (ram_rdata == 8'd0) ? ram_rdata : ram_rdata - 8'd1;
    end
    npx = px + ogru_pkg::POS_W'(dx);
    npy = py + ogru_pkg::POS_W'(dy);
    wpx = npx;
    wtx = tx;
    wpy = npy;
    wty = ty;
    crossed = 1'b0;
    if (npx >= EDGE_P) begin
      wpx = '0; wtx = tx + 16'd1; crossed = 1'b1;
    end else if (npx[ogru_pkg::POS_W-1]) begin
      wpx = LAST_P; wtx = tx - 16'd1; crossed = 1'b1;
    end
    if (npy >= EDGE_P) begin
      wpy = '0; wty = ty + 16'd1; crossed = 1'b1;
    end else if (npy[ogru_pkg::POS_W-1]) begin
      wpy = LAST_P; wty = ty - 16'd1; crossed = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ogru_pkg::ST_CLEAR:
        if (32'(clr_addr) == ogru_pkg::MAP_DEPTH - 1) state_next = ogru_pkg::ST_IDLE;
      ogru_pkg::ST_IDLE:
        if (in_xfer) state_next = in_ch.kind ? ogru_pkg::ST_RDREQ : ogru_pkg::ST_LOCATE;
      ogru_pkg::ST_LOCATE:
        state_next = (!look.hit || too_long) ? ogru_pkg::ST_FINISH : ogru_pkg::ST_DIV;
      ogru_pkg::ST_DIV:
        if (!div_busy) state_next = ogru_pkg::ST_CELL;
      ogru_pkg::ST_CELL:
        state_next = (steps == n_cells || outside) ? ogru_pkg::ST_FINISH : ogru_pkg::ST_UPDATE;
      ogru_pkg::ST_UPDATE:
        state_next = (crossed && !last_cell) ? ogru_pkg::ST_LOOKUP : ogru_pkg::ST_CELL;
      ogru_pkg::ST_LOOKUP:
        state_next = look.hit ? ogru_pkg::ST_CELL : ogru_pkg::ST_FINISH;
      ogru_pkg::ST_RDREQ:  state_next = ogru_pkg::ST_RDDATA;
      ogru_pkg::ST_RDDATA: state_next = ogru_pkg::ST_FINISH;
      ogru_pkg::ST_FINISH:
        if (out_free) state_next = ogru_pkg::ST_IDLE;
      default: state_next = ogru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = upd_val;
    ram_raddr   = cell_addr;
    div_start   = 1'b0;
    unique case (state)
      ogru_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = ogru_pkg::CELL_RESET;
      end
      ogru_pkg::ST_IDLE:   in_ch.ready = 1'b1;
      ogru_pkg::ST_LOCATE: div_start = look.hit && !too_long;
      ogru_pkg::ST_UPDATE: ram_we = 1'b1;
      ogru_pkg::ST_RDREQ:  ram_raddr = rd_ok ? rd_addr : '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ogru_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      coords[0] <= ogru_pkg::SLOT0_RESET;
      coords[1] <= ogru_pkg::SLOT1_RESET;
      coords[2] <= ogru_pkg::SLOT2_RESET;
      coords[3] <= ogru_pkg::SLOT3_RESET;
      present   <= ogru_pkg::PRESENT_RESET;
      pitch     <= ogru_pkg::PITCH_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          ogru_pkg::REG_SLOT0:   coords[0] <= pwdata;
          ogru_pkg::REG_SLOT1:   coords[1] <= pwdata;
          ogru_pkg::REG_SLOT2:   coords[2] <= pwdata;
          ogru_pkg::REG_SLOT3:   coords[3] <= pwdata;
          ogru_pkg::REG_PRESENT: present   <= pwdata[3:0];
          ogru_pkg::REG_PITCH:   pitch     <= pwdata[15:0];
          default: ;
        endcase
      end
      if (state == ogru_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ogru_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (state == ogru_pkg::ST_FINISH && out_free) begin
      out_status <= status;
      out_steps  <= 6'(steps);
      out_value  <= cval;
    end
    unique case (state)
      ogru_pkg::ST_IDLE:
        if (in_xfer) begin
          kind_q  <= in_ch.kind;
          tx      <= in_ch.robot_tile_x;
          ty      <= in_ch.robot_tile_y;
          px      <= ogru_pkg::POS_W'(in_ch.start_x);
          py      <= ogru_pkg::POS_W'(in_ch.start_y);
          dy      <= ogru_pkg::sine_q(ang_idx);
          dx      <= ogru_pkg::sine_q(ang_idx + 7'd32);
          dist_q  <= in_ch.distance;
          rd_slot <= in_ch.read_slot;
          rd_cell <= in_ch.read_cell;
          status  <= ogru_pkg::STATUS_DONE;
          steps   <= '0;
          n_cells <= '0;
          cval    <= 8'd0;
        end
      ogru_pkg::ST_LOCATE: begin
        act <= look.idx;
        if (!look.hit) status <= ogru_pkg::STATUS_NO_TILE;
        else if (too_long) status <= ogru_pkg::STATUS_RANGE;
      end
      ogru_pkg::ST_DIV:
        if (!div_busy) n_cells <= quotient[ogru_pkg::N_W-1:0];
      ogru_pkg::ST_CELL: addr_q <= cell_addr;
      ogru_pkg::ST_UPDATE: begin
        steps <= steps + 1'b1;
        px <= wpx;
        py <= wpy;
        tx <= wtx;
        ty <= wty;
      end
      ogru_pkg::ST_LOOKUP: begin
        act <= look.idx;
        if (!look.hit) status <= ogru_pkg::STATUS_MISSING;
      end
      ogru_pkg::ST_RDDATA: begin
        cval   <= (kind_q && rd_ok) ? ram_rdata : 8'd0;
        status <= ogru_pkg::STATUS_READ;
      end
      default: ;
    endcase
  end
endmodule

FILE: design/ogru_checker.sv
// Port-level checker for the ray update unit, bound to the top level.
// Depends on ogru_pkg, occupancy_grid_ray_update_unit and its channel interfaces.
`timescale 1ns / 1ps
module ogru_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [5:0] steps_done,
  input logic [7:0] cell_value
);
  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(steps_done) &&
    $stable(cell_value))
    else $error("result changed while stalled");

  // One item at a time: the sequencer leaves idle after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_read_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ogru_pkg::STATUS_READ |-> steps_done == 6'd0)
    else $error("read result carries steps");

  a_beam_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ogru_pkg::STATUS_READ |-> cell_value == 8'd0)
    else $error("beam result carries a cell value");

  a_skip_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ogru_pkg::STATUS_NO_TILE || status == ogru_pkg::STATUS_RANGE)
    |-> steps_done == 6'd0)
    else $error("skipped beam wrote cells");
endmodule

bind occupancy_grid_ray_update_unit ogru_checker u_ogru_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
  .steps_done(out_ch.steps_done), .cell_value(out_ch.cell_value)
);

FILE: bench/tb.sv
// Self-checking bench for occupancy_grid_ray_update_unit: directed table, then
// random beams and reads checked against an in-bench map and ray predictor.
// Depends on ogru_pkg, ogru_in_if, ogru_out_if and the design files.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic        kind;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] hdg;
    logic [15:0] bang;
    logic [15:0] rng;
    logic [1:0]  rslot;
    logic [11:0] rcell;
  } scan_req_t;

  typedef struct {
    logic [2:0] status;
    logic [5:0] steps;
    logic [7:0] cval;
  } grid_res_t;

  typedef struct {
    scan_req_t req;
    bit        fixed;
    grid_res_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ogru_in_if  in_ch ();
  ogru_out_if out_ch ();

  occupancy_grid_ray_update_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Mirror of the map and registers.
  logic [7:0]  grid_mem [0:ogru_pkg::MAP_DEPTH-1];
  logic [31:0] slot_xy [0:3];
  logic [3:0]  present_mask;
  logic [15:0] pitch_reg;
  int          sine_tab [0:32] = '{
    0, 3216, 6424, 9616, 12785, 15924, 19024, 22078,
    25080, 28020, 30893, 33692, 36410, 39040, 41576, 44011,
    46341, 48559, 50660, 52639, 54491, 56212, 57798, 59244,
    60547, 61705, 62714, 63572, 64277, 64827, 65220, 65457, 65536};

  grid_res_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int gap_pct = 30;
  int stall_pct = 30;

  function automatic int dir_step(int idx);
    int k, q, v, s;
    k = idx & 31;
    q = (idx >> 5) & 3;
    v = (q & 1) ? sine_tab[32 - k] : sine_tab[k];
    s = (2 * v + (1 << (16 - ogru_pkg::FRAC_BITS))) >> (17 - ogru_pkg::FRAC_BITS);
    return (q & 2) ? -s : s;
  endfunction

  function automatic int lookup_slot(int tx, int ty);
    for (int i = 0; i < ogru_pkg::TILE_SLOTS; i++) begin
      if (present_mask[i] && slot_xy[i] == {tx[15:0], ty[15:0]}) return i;
    end
    return -1;
  endfunction

  // Applies one item to the mirrored map and returns the result it causes.
  function automatic grid_res_t march_ray(scan_req_t r);
    grid_res_t res;
    int pitch, act, n, ang, idx, dx, dy, px, py, tx, ty, xi, yi, addr, v;
    bit crossed;
    res = '{status: ogru_pkg::STATUS_DONE, steps: 6'd0, cval: 8'd0};
    if (r.kind) begin
      if (r.rslot < ogru_pkg::TILE_SLOTS && r.rcell < ogru_pkg::CELLS_PER_TILE)
        res.cval = grid_mem[r.rslot * ogru_pkg::CELLS_PER_TILE + r.rcell];
      res.status = ogru_pkg::STATUS_READ;
      return res;
    end
    tx = r.tile_x;
    ty = r.tile_y;
    pitch = (pitch_reg == 0) ? 1 : pitch_reg;
    act = lookup_slot(tx, ty);
    if (act < 0) begin
      res.status = ogru_pkg::STATUS_NO_TILE;
    end else if (r.rng > (ogru_pkg::TILE_CELLS * pitch) / 2) begin
      res.status = ogru_pkg::STATUS_RANGE;
    end else begin
      n = r.rng / pitch;
      ang = (r.hdg + r.bang) & 16'hFFFF;
      idx = ((ang + 256) >> 9) & 127;
      dy = dir_step(idx);
      dx = dir_step((idx + 32) & 127);
      px = r.sx;
      py = r.sy;
      for (int s = 0; s < n; s++) begin
        xi = px >>> ogru_pkg::FRAC_BITS;
        yi = py >>> ogru_pkg::FRAC_BITS;
        if (px < 0 || py < 0 || xi >= ogru_pkg::TILE_CELLS || yi >= ogru_pkg::TILE_CELLS)
          break;
        addr = act * ogru_pkg::CELLS_PER_TILE + yi * ogru_pkg::TILE_CELLS + xi;
        v = grid_mem[addr];
        if (s + 1 < n) begin
          if (v > 0) v--;
        end else begin
          if (v < 255) v++;
        end
        grid_mem[addr] = v[7:0];
        res.steps++;
        px += dx;
        py += dy;
        crossed = 0;
        if (px >= ogru_pkg::EDGE_POS) begin
          px = 0; tx = (tx + 1) & 16'hFFFF; crossed = 1;
        end else if (px < 0) begin
          px = ogru_pkg::LAST_POS; tx = (tx - 1) & 16'hFFFF; crossed = 1;
        end
        if (py >= ogru_pkg::EDGE_POS) begin
          py = 0; ty = (ty + 1) & 16'hFFFF; crossed = 1;
        end else if (py < 0) begin
          py = ogru_pkg::LAST_POS; ty = (ty - 1) & 16'hFFFF; crossed = 1;
        end
        if (crossed && s + 1 < n) begin
          act = lookup_slot(tx, ty);
          if (act < 0) begin
            res.status = ogru_pkg::STATUS_MISSING;
            break;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      ogru_pkg::REG_PRESENT: present_mask = value[3:0];
      ogru_pkg::REG_PITCH:   pitch_reg = value[15:0];
      default:               slot_xy[idx] = value;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] s0, s1, s2, s3, input logic [3:0] pres,
                          input logic [15:0] pitch);
    write_reg(ogru_pkg::REG_SLOT0, s0);
    write_reg(ogru_pkg::REG_SLOT1, s1);
    write_reg(ogru_pkg::REG_SLOT2, s2);
    write_reg(ogru_pkg::REG_SLOT3, s3);
    write_reg(ogru_pkg::REG_PRESENT, {28'd0, pres});
    write_reg(ogru_pkg::REG_PITCH, {16'd0, pitch});
  endtask

  task automatic drain;
    wait (expected_q.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic send_req(input scan_req_t r, input bit fixed, input grid_res_t fix);
    grid_res_t pred;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid = 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = r.kind;
    in_ch.robot_tile_x = r.tile_x;
    in_ch.robot_tile_y = r.tile_y;
    in_ch.start_x = r.sx;
    in_ch.start_y = r.sy;
    in_ch.heading = r.hdg;
    in_ch.beam_angle = r.bang;
    in_ch.distance = r.rng;
    in_ch.read_slot = r.rslot;
    in_ch.read_cell = r.rcell;
    do @(posedge clk); while (!in_ch.ready);
    pred = march_ray(r);
    expected_q.push_back(fixed ? fix : pred);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic scan_req_t random_req(bit formed);
    scan_req_t r;
    int i, p, top;
    r = '{kind: 1'($urandom_range(0, 1)), tile_x: 16'($urandom), tile_y: 16'($urandom),
          sx: 16'($urandom), sy: 16'($urandom), hdg: 16'($urandom), bang: 16'($urandom),
          rng: 16'($urandom), rslot: 2'($urandom), rcell: 12'($urandom)};
    if (!formed) return r;
    r.kind = ($urandom_range(0, 99) < 20);
    if (present_mask != 0) begin
      do i = $urandom_range(0, 3); while (!present_mask[i]);
      r.tile_x = slot_xy[i][31:16];
      r.tile_y = slot_xy[i][15:0];
    end
    p = (pitch_reg == 0) ? 1 : pitch_reg;
    top = (ogru_pkg::TILE_CELLS / 2) * p;
    case ($urandom_range(0, 9))
      0: r.rng = 16'((top > 65535) ? 65535 : top);
      1: r.rng = 16'((top + 1 > 65535) ? 65535 : top + 1);
      default: r.rng = 16'($urandom_range(0, (top > 65535) ? 65535 : top));
    endcase
    return r;
  endfunction

  task automatic random_run(input int count);
    grid_res_t none;
    none = '{default: '0};
    for (int k = 0; k < count; k++)
      send_req(random_req($urandom_range(0, 99) < 88), 1'b0, none);
  endtask

  function automatic table_row_t row(logic kind, logic [15:0] tx, ty, sx, sy, hdg, bang,
                                     rng, logic [1:0] rs, logic [11:0] rc, bit fixed,
                                     logic [2:0] st, logic [5:0] steps, logic [7:0] cv);
    table_row_t t;
    t.req = '{kind, tx, ty, sx, sy, hdg, bang, rng, rs, rc};
    t.fixed = fixed;
    t.res = '{st, steps, cv};
    return t;
  endfunction

  // Receiver: random stalls, one long hold-off so the unit backs up.
  initial begin
    grid_res_t e;
    bit held;
    held = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result status=%0d", out_ch.status);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.status !== e.status || out_ch.steps_done !== e.steps ||
              out_ch.cell_value !== e.cval) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected status=%0d steps=%0d cell=%0d, got %0d %0d %0d",
                       e.status, e.steps, e.cval, out_ch.status, out_ch.steps_done,
                       out_ch.cell_value);
          end
        end
      end
      @(negedge clk);
      if (results_seen >= 400 && !held) begin
        held = 1;
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
      end else if ($urandom_range(0, 99) < 2 && stall_pct > 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    table_row_t dir [$];
    grid_res_t none;
    scan_req_t hammer;
    none = '{default: '0};
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.robot_tile_x = '0; in_ch.robot_tile_y = '0;
    in_ch.start_x = '0; in_ch.start_y = '0;
    in_ch.heading = '0; in_ch.beam_angle = '0; in_ch.distance = '0;
    in_ch.read_slot = '0; in_ch.read_cell = '0;
    for (int a = 0; a < ogru_pkg::MAP_DEPTH; a++) grid_mem[a] = ogru_pkg::CELL_RESET;
    slot_xy[0] = ogru_pkg::SLOT0_RESET; slot_xy[1] = ogru_pkg::SLOT1_RESET;
    slot_xy[2] = ogru_pkg::SLOT2_RESET; slot_xy[3] = ogru_pkg::SLOT3_RESET;
    present_mask = ogru_pkg::PRESENT_RESET;
    pitch_reg = ogru_pkg::PITCH_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at reset settings.
    dir.push_back(row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ogru_pkg::STATUS_READ, 0,
                      ogru_pkg::CELL_RESET));
    dir.push_back(row(1, 0, 0, 0, 0, 0, 0, 0, 3, 4095, 1, ogru_pkg::STATUS_READ, 0,
                      ogru_pkg::CELL_RESET));
    dir.push_back(row(0, 5, 5, 0, 0, 0, 0, 10, 0, 0, 1, ogru_pkg::STATUS_NO_TILE, 0, 0));
    dir.push_back(row(0, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 10, 0, 0, 1,
                      ogru_pkg::STATUS_NO_TILE, 0, 0));
    dir.push_back(row(0, 0, 0, 0, 0, 0, 0, 321, 0, 0, 1, ogru_pkg::STATUS_RANGE, 0, 0));
    dir.push_back(row(0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, 1, ogru_pkg::STATUS_RANGE, 0, 0));
    dir.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ogru_pkg::STATUS_DONE, 0, 0));
    dir.push_back(row(0, 0, 0, 16'd1024, 16'd1024, 0, 0, 320, 0, 0, 0, 0, 0, 0));
    // Crossing the east edge into an absent tile, then south into slot 1.
    dir.push_back(row(0, 0, 0, 16'd65024, 16'd32768, 0, 0, 100, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(0, 0, 0, 16'd2000, 16'd512, 16'd49152, 0, 200, 0, 0, 0, 0, 0, 0));
    // Diagonal crossing into slot 3, and angle sums that wrap.
    dir.push_back(row(0, 0, 0, 16'd512, 16'd512, 16'd40960, 0, 100, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(0, 0, 0, 16'd9000, 16'd9000, 16'hFFFF, 16'd1, 300, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16384, 16'd16384,
                      150, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(0, 0, 16'hFFFF, 16'd30000, 16'd30000, 16'd32768, 16'hFFFF,
                      310, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(1, 0, 0, 0, 0, 0, 0, 0, 0, 12'd33, 0, 0, 0, 0));
    dir.push_back(row(1, 0, 0, 0, 0, 0, 0, 0, 1, 12'd1985, 0, 0, 0, 0));
    dir.push_back(row(1, 0, 0, 0, 0, 0, 0, 0, 3, 12'd4032, 0, 0, 0, 0));
    foreach (dir[i]) send_req(dir[i].req, dir[i].fixed, dir[i].res);
    random_run(200);
    drain();

    // Adjacent tiles so rays hop between slots; no input gaps and no random receiver stalls.
    gap_pct = 0; stall_pct = 0;
    set_regs(32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 32'h0001_0001, 4'hF, 16'd10);
    random_run(240);
    drain();

    // Tiles at the 16-bit wrap of the coordinates, smallest pitch.
    gap_pct = 40; stall_pct = 40;
    set_regs(32'h7FFF_7FFF, 32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_8000, 4'hF, 16'd1);
    random_run(240);
    drain();

    // No tile present, largest pitch.
    set_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0, 16'hFFFF);
    random_run(60);
    drain();
    // One slot present with the largest pitch: at most one cell per beam.
    write_reg(ogru_pkg::REG_PRESENT, 32'h2);
    random_run(80);
    drain();

    // Duplicate coordinates: the lowest present slot must win. Pitch zero acts as one.
    set_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'hE, 16'd0);
    random_run(180);
    drain();

    // Same ray over and over drives cells to both clamps.
    gap_pct = 20; stall_pct = 20;
    set_regs(32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 32'h0001_0001, 4'h1, 16'd20);
    hammer = '{kind: 1'b0, tile_x: 16'd0, tile_y: 16'd0, sx: 16'd10752, sy: 16'd10752,
               hdg: 16'd8192, bang: 16'd0, rng: 16'd640, rslot: 2'd0, rcell: 12'd0};
    for (int k = 0; k < 300; k++) begin
      if (k % 5 == 4)
        send_req(random_req(1), 1'b0, none);
      else
        send_req(hammer, 1'b0, none);
    end
    random_run(100);

    in_ch.valid = 1'b0;
    drain();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
